FILE: rtl/adpcmb_pkg.sv
// Shared types, constants and the step scaling table for the ADPCM-B encoder.
// No dependencies; every other file of the block refers to it by scoped names.
package adpcmb_pkg;

	localparam int SAMPLE_W   = 16;            // PCM sample width
	localparam int STEP_W     = 15;            // quantizer step width
	localparam int MAG_W      = 3;             // code magnitude width
	localparam int CODE_W     = 4;             // one ADPCM nibble
	localparam int REM_W      = SAMPLE_W + 2;  // 4*|d|
	localparam int QUANT_STEPS = 4;            // clamp bit + three quotient bits
	localparam int QCNT_W     = $clog2(QUANT_STEPS);

	localparam logic [STEP_W-1:0] STEP_MIN = 15'd127;
	localparam logic [STEP_W-1:0] STEP_MAX = 15'd24576;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_UPD
	} enc_state_t;

	// Status from the serial quantizer to the controller
	typedef struct packed {
		logic             last_step;  // final quotient digit is being resolved
		logic [MAG_W-1:0] mag;        // clamped magnitude, valid after last_step
	} quant_status_t;

	// Step adaptation factor, indexed by code magnitude
	function automatic logic [7:0] step_factor(input logic [MAG_W-1:0] mag);
		logic [7:0] f;
		case (mag)
			3'd4:    f = 8'd77;
			3'd5:    f = 8'd102;
			3'd6:    f = 8'd128;
			3'd7:    f = 8'd153;
			default: f = 8'd57;
		endcase
		return f;
	endfunction

endpackage

FILE: rtl/adpcmb_ifs.sv
// Valid/ready channel interfaces for the ADPCM-B encoder: PCM samples in,
// packed code bytes out. Depends on adpcmb_pkg for field widths.
interface adpcmb_sample_if;
	logic                               valid;
	logic                               ready;
	logic signed [adpcmb_pkg::SAMPLE_W-1:0] sample;
	logic                               last_sample;

	modport source (output valid, output sample, output last_sample, input ready);
	modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface adpcmb_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] code_byte;
	logic       end_of_stream;

	modport source (output valid, output code_byte, output end_of_stream, input ready);
	modport sink   (input valid, input code_byte, input end_of_stream, output ready);
endinterface

FILE: rtl/adpcm_b_nibble_encoder.sv
// ADPCM-B nibble encoder top level: controller, nibble packer, output register.
// Depends on adpcmb_pkg, adpcmb_ifs, adpcmb_quant and adpcmb_predict.
// Flow: a new sample is accepted only in idle, after the previous one has been
//   coded; the bit-serial quantizer resolves one quotient digit per cycle, and a
//   stalled output register holds updates.
// Reset: arst_n clears predictor to 0, step to 127, packer and output valid.
module adpcm_b_nibble_encoder (
	input  logic                   clk,
	input  logic                   arst_n,
	adpcmb_sample_if.sink          sample_ch,
	adpcmb_byte_if.source          byte_ch
);

	adpcmb_pkg::enc_state_t    state_q, state_nxt;
	adpcmb_pkg::quant_status_t qstat;

	logic signed [adpcmb_pkg::SAMPLE_W-1:0] pred;
	logic [adpcmb_pkg::STEP_W-1:0]          step;
	logic [adpcmb_pkg::SAMPLE_W-1:0]        smask;
	logic [16:0]                            diff;
	logic [16:0]                            ndiff;
	logic [adpcmb_pkg::SAMPLE_W-1:0]        mag_d;
	logic [adpcmb_pkg::REM_W-1:0]           rem_init;
	logic                                   accept;
	logic                                   emit;
	logic                                   out_free;
	logic                                   upd_go;
	logic [adpcmb_pkg::CODE_W-1:0]          code;

	logic                                   neg_q;
	logic                                   last_q;
	logic                                   half_q;
	logic [adpcmb_pkg::CODE_W-1:0]          pend_q;
	logic                                   ovalid_q;
	logic [7:0]                             obyte_q;
	logic                                   oeos_q;

	// difference against predictor, low three sample bits cleared
	always_comb begin
		smask    = {sample_ch.sample[15:3], 3'b000};
		diff     = {smask[15], smask} - {pred[15], pred};
		ndiff    = 17'd0 - diff;
		mag_d    = diff[16] ? ndiff[15:0] : diff[15:0];
		rem_init = {mag_d, 2'b00};
	end

	adpcmb_quant u_quant (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.rem_init (rem_init),
		.step     (step),
		.status   (qstat)
	);

	assign code = {neg_q, qstat.mag};

	adpcmb_predict u_predict (
		.clk     (clk),
		.arst_n  (arst_n),
		.update  (upd_go),
		.restart (last_q),
		.neg     (neg_q),
		.mag     (qstat.mag),
		.pred    (pred),
		.step    (step)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			adpcmb_pkg::ST_IDLE: if (sample_ch.valid) state_nxt = adpcmb_pkg::ST_DIV;
			adpcmb_pkg::ST_DIV:  if (qstat.last_step) state_nxt = adpcmb_pkg::ST_UPD;
			adpcmb_pkg::ST_UPD:  if (upd_go) state_nxt = adpcmb_pkg::ST_IDLE;
			default:             state_nxt = adpcmb_pkg::ST_IDLE;
		endcase
	end

	// controller outputs
	always_comb begin
		sample_ch.ready = 1'b0;
		upd_go          = 1'b0;
		case (state_q)
			adpcmb_pkg::ST_IDLE: sample_ch.ready = 1'b1;
			adpcmb_pkg::ST_UPD:  upd_go = !emit || out_free;
			default: ;
		endcase
	end

	assign accept   = sample_ch.valid && sample_ch.ready;
	assign emit     = half_q || last_q;
	assign out_free = !ovalid_q || byte_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= adpcmb_pkg::ST_IDLE;
		else
			state_q <= state_nxt;
	end

	// per-sample flags captured at the input beat
	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q  <= diff[16];
			last_q <= sample_ch.last_sample;
		end
	end

	// nibble packer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= 1'b0;
			pend_q <= '0;
		end else if (upd_go) begin
			if (half_q || last_q) begin
				half_q <= 1'b0;
				pend_q <= '0;
			end else begin
				half_q <= 1'b1;
				pend_q <= code;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ovalid_q <= 1'b0;
		else if (upd_go && emit)
			ovalid_q <= 1'b1;
		else if (byte_ch.ready)
			ovalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (upd_go && emit) begin
			obyte_q <= half_q ? {pend_q, code} : {code, 4'b0000};
			oeos_q  <= last_q;
		end
	end

	assign byte_ch.valid         = ovalid_q;
	assign byte_ch.code_byte     = obyte_q;
	assign byte_ch.end_of_stream = oeos_q;

endmodule

FILE: rtl/adpcmb_quant.sv
// Bit-serial quantizer: floor(4*|d|/step) clamped to 7, one quotient digit
// per cycle by restoring division. Depends on adpcmb_pkg.
module adpcmb_quant (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [adpcmb_pkg::REM_W-1:0]      rem_init,
	input  logic [adpcmb_pkg::STEP_W-1:0]     step,
	output adpcmb_pkg::quant_status_t         status
);

	logic                              run_q;
	logic [adpcmb_pkg::QCNT_W-1:0]     cnt_q;
	logic [adpcmb_pkg::REM_W-1:0]      rem_q;
	logic [adpcmb_pkg::REM_W-1:0]      dvs_q;
	logic [adpcmb_pkg::QUANT_STEPS-1:0] quo_q;
	logic                              ge;
	logic                              last_step;

	// trial subtract of the current divisor weight
	assign ge        = rem_q >= dvs_q;
	assign last_step = run_q && (cnt_q == adpcmb_pkg::QCNT_W'(adpcmb_pkg::QUANT_STEPS - 1));

	// control: step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (last_step)
				run_q <= 1'b0;
		end
	end

	// datapath: remainder, shifting divisor, quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			dvs_q <= {step, 3'b000};   // first digit tests 8*step (clamp)
		end else if (run_q) begin
			if (ge)
				rem_q <= rem_q - dvs_q;
			dvs_q <= {1'b0, dvs_q[adpcmb_pkg::REM_W-1:1]};
			quo_q <= {quo_q[adpcmb_pkg::QUANT_STEPS-2:0], ge};
		end
	end

	assign status.last_step = last_step;
	assign status.mag = quo_q[adpcmb_pkg::QUANT_STEPS-1] ? 3'd7 :
	                    quo_q[adpcmb_pkg::MAG_W-1:0];

endmodule

FILE: rtl/adpcmb_predict.sv
// Predictor and step-size state with their saturating update per code.
// Depends on adpcmb_pkg (widths, step limits, step factor table).
module adpcmb_predict (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  update,
	input  logic                                  restart,
	input  logic                                  neg,
	input  logic [adpcmb_pkg::MAG_W-1:0]          mag,
	output logic signed [adpcmb_pkg::SAMPLE_W-1:0] pred,
	output logic [adpcmb_pkg::STEP_W-1:0]         step
);

	logic signed [adpcmb_pkg::SAMPLE_W-1:0] pred_q;
	logic [adpcmb_pkg::STEP_W-1:0]          step_q;
	logic [3:0]                             odd;
	logic [18:0]                            prod;
	logic [15:0]                            delta;
	logic signed [17:0]                     pv_ext;
	logic signed [17:0]                     nv;
	logic signed [adpcmb_pkg::SAMPLE_W-1:0] pred_next;
	logic [21:0]                            scale;
	logic [15:0]                            ns;
	logic [adpcmb_pkg::STEP_W-1:0]          step_next;

	// predictor move: ((2*mag+1)*step)>>3, saturated to 16 bits
	always_comb begin
		odd    = {mag, 1'b1};
		prod   = 19'(odd) * 19'(step_q);
		delta  = prod[18:3];
		pv_ext = 18'(pred_q);
		nv     = neg ? (pv_ext - $signed({2'b00, delta})) : (pv_ext + $signed({2'b00, delta}));
		if (nv > 18'sd32767)
			pred_next = 16'sh7FFF;
		else if (nv < -18'sd32768)
			pred_next = 16'sh8000;
		else
			pred_next = nv[15:0];
	end

	// step adaptation: factor*step>>6, clamped
	always_comb begin
		scale = 22'(adpcmb_pkg::step_factor(mag)) * 22'(step_q);
		ns    = scale[21:6];
		if (ns < 16'(adpcmb_pkg::STEP_MIN))
			step_next = adpcmb_pkg::STEP_MIN;
		else if (ns > 16'(adpcmb_pkg::STEP_MAX))
			step_next = adpcmb_pkg::STEP_MAX;
		else
			step_next = ns[adpcmb_pkg::STEP_W-1:0];
	end

	// state registers; end of stream returns to reset values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pred_q <= '0;
			step_q <= adpcmb_pkg::STEP_MIN;
		end else if (update) begin
			if (restart) begin
				pred_q <= '0;
				step_q <= adpcmb_pkg::STEP_MIN;
			end else begin
				pred_q <= pred_next;
				step_q <= step_next;
			end
		end
	end

	assign pred = pred_q;
	assign step = step_q;

endmodule
